### src/mfde_pkg.sv
`default_nettype none

package mfde_pkg;

  localparam int DISP_WIDTH  = 128;
  localparam int DISP_HEIGHT = 64;
  localparam int STORE_BYTES = DISP_WIDTH * ((DISP_HEIGHT + 7) / 8);
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = 12;

  localparam logic [2:0] KIND_CLEAR = 3'd0;
  localparam logic [2:0] KIND_PIXEL = 3'd1;
  localparam logic [2:0] KIND_HLINE = 3'd2;
  localparam logic [2:0] KIND_RECT  = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic [1:0] FB_OP_PIX = 2'd0;
  localparam logic [1:0] FB_OP_CLR = 2'd1;
  localparam logic [1:0] FB_OP_RD  = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic [7:0] span_w;
    logic [7:0] span_h;
    logic       ink;
    logic [9:0] byte_index;
  } cmd_t;

  typedef struct packed {
    logic          vld;
    logic [1:0]    op;
    logic [AW-1:0] addr;
    logic [2:0]    bit_sel;
    logic          ink;
  } fb_req_t;

  typedef struct packed {
    logic       rdy;
    logic       done;
    logic [7:0] data;
  } fb_rsp_t;

  typedef struct packed {
    logic       vld;
    logic [2:0] kind;
    logic [7:0] data;
  } seq_res_t;

endpackage

`default_nettype wire

### src/mfde_fb.sv
`default_nettype none

module mfde_fb (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mfde_pkg::fb_req_t req,
  output mfde_pkg::fb_rsp_t      rsp
);
  import mfde_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_CLR  = 2'd1;
  localparam logic [1:0] F_PRD  = 2'd2;
  localparam logic [1:0] F_RRD  = 2'd3;

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    rdata_r;
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [AW-1:0] addr_r;
  logic [2:0]    bit_r;
  logic          ink_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    mask;
  logic          clr_last;

  assign mask     = 8'(1) << bit_r;
  assign clr_last = (clr_addr_r == AW'(STORE_BYTES - 1));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[req.addr];
  end

  always_comb begin
    we           = 1'b0;
    waddr        = addr_r;
    wdata        = ink_r ? (rdata_r | mask) : (rdata_r & ~mask);
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    rsp.rdy      = 1'b0;
    rsp.done     = 1'b0;
    rsp.data     = rdata_r;
    case (state_r)
      F_IDLE: begin
        rsp.rdy = 1'b1;
        if (req.vld) begin
          case (req.op)
            FB_OP_PIX: state_nxt = F_PRD;
            FB_OP_CLR: begin
              state_nxt    = F_CLR;
              clr_addr_nxt = '0;
            end
            FB_OP_RD:  state_nxt = F_RRD;
            default:   state_nxt = F_IDLE;
          endcase
        end
      end
      F_CLR: begin
        we           = 1'b1;
        waddr        = clr_addr_r;
        wdata        = 8'h00;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_last) begin
          rsp.done  = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      F_PRD: begin
        we        = 1'b1;
        rsp.done  = 1'b1;
        state_nxt = F_IDLE;
      end
      F_RRD: begin
        rsp.done  = 1'b1;
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_CLR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == F_IDLE) && req.vld && (req.op == FB_OP_PIX)) begin
      addr_r <= req.addr;
      bit_r  <= req.bit_sel;
      ink_r  <= req.ink;
    end
  end

endmodule

`default_nettype wire

### src/mfde_seq.sv
`default_nettype none

module mfde_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmd_vld,
  input  wire mfde_pkg::cmd_t     cmd,
  output logic                    idle,
  output mfde_pkg::fb_req_t       fb_req,
  input  wire mfde_pkg::fb_rsp_t  fb_rsp,
  output mfde_pkg::seq_res_t      res,
  input  wire logic               res_rdy
);
  import mfde_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_OP   = 3'd2;
  localparam logic [2:0] S_PIX  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_STEP = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [2:0] PH_ONE   = 3'd0;
  localparam logic [2:0] PH_TOP   = 3'd1;
  localparam logic [2:0] PH_BOT   = 3'd2;
  localparam logic [2:0] PH_LEFT  = 3'd3;
  localparam logic [2:0] PH_RIGHT = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [1:0]    prep_r, prep_nxt;
  logic [8:0]    cnt_r, cnt_nxt;
  logic [CW-1:0] cur_x_r, cur_x_nxt;
  logic [CW-1:0] cur_y_r, cur_y_nxt;
  logic [CW-1:0] xe_r, xe_nxt;
  logic [CW-1:0] ye_r, ye_nxt;
  logic [7:0]    rd_r, rd_nxt;
  logic [2:0]    kind_r;
  logic [CW-1:0] x0_r, y0_r;
  logic [7:0]    w_r, h_r;
  logic          ink_r;
  logic [9:0]    bi_r;

  logic [CW-1:0] add_a, add_b, sum;
  logic [CW-1:0] px, py;
  logic          on_screen;
  logic          left;
  logic          bi_ok;
  logic [CW-1:0] sx, sy;

  assign sum   = add_a + add_b;
  assign sx    = {{(CW-10){cmd.pos_x[9]}}, cmd.pos_x};
  assign sy    = {{(CW-10){cmd.pos_y[9]}}, cmd.pos_y};
  assign bi_ok = (32'(cmd.byte_index) < STORE_BYTES);
  assign idle  = (state_r == S_IDLE);

  always_comb begin
    add_a = cur_x_r;
    add_b = CW'(1);
    if (state_r == S_PREP) begin
      case (prep_r)
        2'd0: begin
          add_a = x0_r;
          add_b = CW'(w_r);
        end
        2'd1: begin
          add_a = xe_r;
          add_b = '1;
        end
        2'd2: begin
          add_a = y0_r;
          add_b = CW'(h_r);
        end
        default: begin
          add_a = ye_r;
          add_b = '1;
        end
      endcase
    end else if (phase_r == PH_RIGHT) begin
      add_a = cur_y_r;
    end
  end

  always_comb begin
    case (phase_r)
      PH_LEFT:  px = x0_r;
      PH_RIGHT: px = xe_r;
      default:  px = cur_x_r;
    endcase
    py = cur_y_r;
    on_screen = !px[CW-1] && (px < CW'(DISP_WIDTH)) &&
                !py[CW-1] && (py < CW'(DISP_HEIGHT));
    case (phase_r)
      PH_TOP, PH_BOT: left = (cnt_r < {1'b0, w_r});
      PH_LEFT:        left = (cnt_r < {1'b0, h_r});
      default:        left = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    prep_nxt       = prep_r;
    cnt_nxt        = cnt_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    xe_nxt         = xe_r;
    ye_nxt         = ye_r;
    rd_nxt         = rd_r;
    fb_req.vld     = 1'b0;
    fb_req.op      = FB_OP_PIX;
    fb_req.addr    = AW'(32'(py[CW-1:3]) * DISP_WIDTH + 32'(px));
    fb_req.bit_sel = py[2:0];
    fb_req.ink     = ink_r;
    res.vld        = 1'b0;
    res.kind       = kind_r;
    res.data       = rd_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_vld) begin
          rd_nxt    = 8'h00;
          cnt_nxt   = '0;
          prep_nxt  = '0;
          cur_x_nxt = sx;
          cur_y_nxt = sy;
          case (cmd.kind)
            KIND_CLEAR: state_nxt = S_OP;
            KIND_PIXEL: begin
              state_nxt = S_PIX;
              phase_nxt = PH_ONE;
            end
            KIND_HLINE: begin
              state_nxt = S_PIX;
              phase_nxt = PH_TOP;
            end
            KIND_RECT: begin
              state_nxt = S_PREP;
              phase_nxt = PH_TOP;
            end
            KIND_READ: state_nxt = bi_ok ? S_OP : S_FIN;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_PREP: begin
        prep_nxt = prep_r + 2'd1;
        if (prep_r[1]) begin
          ye_nxt = sum;
        end else begin
          xe_nxt = sum;
        end
        if (prep_r == 2'd3) begin
          state_nxt = S_PIX;
        end
      end
      S_OP: begin
        fb_req.vld  = 1'b1;
        fb_req.op   = (kind_r == KIND_CLEAR) ? FB_OP_CLR : FB_OP_RD;
        fb_req.addr = AW'(bi_r);
        if (fb_rsp.rdy) begin
          state_nxt = S_WAIT;
        end
      end
      S_PIX: begin
        if (!left) begin
          case (phase_r)
            PH_TOP: begin
              if (kind_r == KIND_HLINE) begin
                state_nxt = S_FIN;
              end else begin
                phase_nxt = PH_BOT;
                cur_x_nxt = x0_r;
                cur_y_nxt = ye_r;
                cnt_nxt   = '0;
              end
            end
            PH_BOT: begin
              phase_nxt = PH_LEFT;
              cur_y_nxt = y0_r;
              cnt_nxt   = '0;
            end
            default: state_nxt = S_FIN;
          endcase
        end else if (!on_screen) begin
          state_nxt = S_STEP;
        end else begin
          fb_req.vld = 1'b1;
          if (fb_rsp.rdy) begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (fb_rsp.done) begin
          if (kind_r == KIND_READ) begin
            rd_nxt = fb_rsp.data;
          end
          if ((kind_r == KIND_CLEAR) || (kind_r == KIND_READ)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_STEP;
          end
        end
      end
      S_STEP: begin
        state_nxt = S_PIX;
        case (phase_r)
          PH_TOP, PH_BOT: begin
            cur_x_nxt = sum;
            cnt_nxt   = cnt_r + 9'd1;
          end
          PH_LEFT: phase_nxt = PH_RIGHT;
          PH_RIGHT: begin
            cur_y_nxt = sum;
            cnt_nxt   = cnt_r + 9'd1;
            phase_nxt = PH_LEFT;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_FIN: begin
        res.vld = 1'b1;
        if (res_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_ONE;
      prep_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      prep_r  <= prep_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    xe_r    <= xe_nxt;
    ye_r    <= ye_nxt;
    rd_r    <= rd_nxt;
    if (idle && cmd_vld) begin
      kind_r <= cmd.kind;
      x0_r   <= sx;
      y0_r   <= sy;
      w_r    <= cmd.span_w;
      h_r    <= cmd.span_h;
      ink_r  <= cmd.ink;
      bi_r   <= cmd.byte_index;
    end
  end

endmodule

`default_nettype wire

### src/mono_framebuffer_draw_engine_unit.sv
// Commands run one at a time. A drawn pixel is a read-modify-write of its byte in the store, while
// a clipped pixel skips the store access. A result word becomes valid in the same cycle as the
// next command can first be accepted, and it may wait in its register while the next command runs.
// Reset is synchronous and active low; a clearing pass then zeroes every byte of the store, and no
// command is taken until it ends.
`default_nettype none

module mono_framebuffer_draw_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,  // pos_x, pos_y, span_w, span_h, ink, byte_index, zero pad
  input  wire logic [2:0]  in_tuser,  // kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // read_byte
  output logic [2:0]       out_tuser  // done_kind
);
  import mfde_pkg::*;

  cmd_t     cmd;
  fb_req_t  fb_req;
  fb_rsp_t  fb_rsp;
  seq_res_t res;
  logic     seq_idle;
  logic     accept;
  logic     slot_free;
  logic     out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r;
  logic [7:0] out_byte_r;

  assign cmd.kind       = in_tuser;
  assign cmd.pos_x      = in_tdata[9:0];
  assign cmd.pos_y      = in_tdata[19:10];
  assign cmd.span_w     = in_tdata[27:20];
  assign cmd.span_h     = in_tdata[35:28];
  assign cmd.ink        = in_tdata[36];
  assign cmd.byte_index = in_tdata[46:37];

  assign in_tready = seq_idle && fb_rsp.rdy;
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  mfde_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_vld (accept),
    .cmd     (cmd),
    .idle    (seq_idle),
    .fb_req  (fb_req),
    .fb_rsp  (fb_rsp),
    .res     (res),
    .res_rdy (slot_free)
  );

  mfde_fb u_fb (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fb_req),
    .rsp   (fb_rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.vld && slot_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld && slot_free) begin
      out_kind_r <= res.kind;
      out_byte_r <= res.data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_kind_r;

endmodule

`default_nettype wire

### tb/mono_framebuffer_draw_engine_unit_tb.sv
`timescale 1ns / 100ps

module mono_framebuffer_draw_engine_unit_tb;
  import mfde_pkg::*;

  localparam logic [2:0] KIND_LAST = 3'd7;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 100;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct {
    cmd_t cmd;
    bit   wait_idle;
  } stim_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } result_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_BEAT} sink_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;

  logic [7:0]  pix_store [0:STORE_BYTES-1];
  stim_t       cmd_queue [$];
  result_t     result_queue [$];
  cmd_t        cur_cmd;
  result_t     want;
  int          burst_left = 0;
  int          gap_left = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  sink_mode_t  sink_mode = SINK_OPEN;
  int          sink_left = 0;
  int          sink_tick = 0;

  mono_framebuffer_draw_engine_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void plot(int x, int y, bit on);
    int idx;
    if (x < 0 || x >= DISP_WIDTH || y < 0 || y >= DISP_HEIGHT) return;
    idx = (y / 8) * DISP_WIDTH + x;
    pix_store[idx][y % 8] = on;
  endfunction

  function automatic void plot_row(int x, int y, int w, bit on);
    for (int i = 0; i < w; i++) plot(x + i, y, on);
  endfunction

  function automatic logic [7:0] run_command(cmd_t c);
    int x, y, w, h;
    logic [7:0] rd;
    x = $signed(c.pos_x);
    y = $signed(c.pos_y);
    w = c.span_w;
    h = c.span_h;
    rd = 8'h00;
    case (c.kind)
      KIND_CLEAR: begin
        foreach (pix_store[i]) pix_store[i] = 8'h00;
      end
      KIND_PIXEL: plot(x, y, c.ink);
      KIND_HLINE: plot_row(x, y, w, c.ink);
      KIND_RECT: begin
        plot_row(x, y, w, c.ink);
        plot_row(x, y + h - 1, w, c.ink);
        for (int i = 0; i < h; i++) begin
          plot(x, y + i, c.ink);
          plot(x + w - 1, y + i, c.ink);
        end
      end
      KIND_READ: begin
        if (c.byte_index < STORE_BYTES) rd = pix_store[c.byte_index];
      end
      default: ;
    endcase
    return rd;
  endfunction

  function automatic cmd_t random_cmd();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[$bits(cmd_t)-1:0];
  endfunction

  function automatic cmd_t draw_cmd(logic [2:0] k, int x, int y, int w, int h, bit on);
    cmd_t c;
    c = random_cmd();
    c.kind = k;
    c.pos_x = 10'(x);
    c.pos_y = 10'(y);
    c.span_w = 8'(w);
    c.span_h = 8'(h);
    c.ink = on;
    return c;
  endfunction

  function automatic cmd_t read_cmd(int idx);
    cmd_t c;
    c = random_cmd();
    c.kind = KIND_READ;
    c.byte_index = 10'(idx);
    return c;
  endfunction

  function automatic void queue_cmd(cmd_t c, bit hold);
    cmd_queue.push_back('{cmd: c, wait_idle: hold});
  endfunction

  function automatic int pick_x();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, DISP_WIDTH + 15)) - 8;
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  function automatic int pick_y();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, DISP_HEIGHT + 15)) - 8;
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  function automatic int pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 20);
    if (r < 95) return $urandom_range(0, 80);
    return $urandom_range(0, 255);
  endfunction

  // Sender: bursts of words separated by random gaps; an item flagged wait_idle
  // is held back until every outstanding result has been returned.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        result_queue.push_back('{kind: cur_cmd.kind, data: run_command(cur_cmd)});
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_queue.size() == 0 || (cmd_queue[0].wait_idle && result_queue.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          cur_cmd = cmd_queue.pop_front().cmd;
          in_tvalid <= 1'b1;
          in_tdata <= {1'b0, cur_cmd.byte_index, cur_cmd.ink, cur_cmd.span_h, cur_cmd.span_w,
                       cur_cmd.pos_y, cur_cmd.pos_x};
          in_tuser <= cur_cmd.kind;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_left = 0;
      sink_tick = 0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(0, 3));
        sink_left = $urandom_range(20, 400);
      end
      sink_left--;
      sink_tick++;
      case (sink_mode)
        SINK_OPEN:   out_tready <= 1'b1;
        SINK_COIN:   out_tready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:     out_tready <= ((sink_tick % 8) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: done_kind %0d read_byte %02h", out_tuser, out_tdata);
        end
      end else begin
        want = result_queue.pop_front();
        if (out_tuser !== want.kind || out_tdata !== want.data) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("word mismatch: expected done_kind %0d read_byte %02h, got %0d %02h",
                     want.kind, want.data, out_tuser, out_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cmd_t c;
    int r, lx, ly;
    foreach (pix_store[i]) pix_store[i] = 8'h00;

    queue_cmd(read_cmd(0), 1'b0);
    queue_cmd(read_cmd(STORE_BYTES - 1), 1'b0);
    queue_cmd(draw_cmd(KIND_PIXEL, 0, 0, 0, 0, 1'b1), 1'b0);
    queue_cmd(draw_cmd(KIND_PIXEL, DISP_WIDTH - 1, DISP_HEIGHT - 1, 255, 255, 1'b1), 1'b0);
    queue_cmd(draw_cmd(KIND_PIXEL, -512, -512, 0, 0, 1'b1), 1'b0);
    queue_cmd(draw_cmd(KIND_PIXEL, 511, 511, 0, 0, 1'b1), 1'b0);
    queue_cmd(draw_cmd(KIND_PIXEL, DISP_WIDTH, 0, 0, 0, 1'b1), 1'b0);
    queue_cmd(draw_cmd(KIND_PIXEL, 0, DISP_HEIGHT, 0, 0, 1'b1), 1'b0);
    queue_cmd(read_cmd(0), 1'b0);
    queue_cmd(read_cmd(STORE_BYTES - 1), 1'b0);
    queue_cmd(draw_cmd(KIND_HLINE, -5, 8, 255, 0, 1'b1), 1'b0);
    queue_cmd(draw_cmd(KIND_HLINE, 10, 10, 0, 0, 1'b1), 1'b0);
    queue_cmd(read_cmd(DISP_WIDTH + 10), 1'b0);
    queue_cmd(draw_cmd(KIND_RECT, 20, 20, 10, 6, 1'b1), 1'b0);
    queue_cmd(draw_cmd(KIND_RECT, 40, 2, 0, 5, 1'b1), 1'b0);
    queue_cmd(draw_cmd(KIND_RECT, 50, 30, 8, 0, 1'b1), 1'b0);
    queue_cmd(draw_cmd(KIND_RECT, 60, 40, 1, 1, 1'b1), 1'b0);
    queue_cmd(read_cmd(2 * DISP_WIDTH + 20), 1'b0);
    queue_cmd(read_cmd(39), 1'b0);
    queue_cmd(read_cmd(3 * DISP_WIDTH + 50), 1'b0);
    queue_cmd(draw_cmd(KIND_RECT, -100, -100, 255, 255, 1'b1), 1'b0);
    queue_cmd(draw_cmd(KIND_PIXEL, 0, 0, 0, 0, 1'b0), 1'b0);
    queue_cmd(read_cmd(0), 1'b0);
    for (int k = KIND_READ + 1; k <= KIND_LAST; k++) begin
      c = random_cmd();
      c.kind = 3'(k);
      queue_cmd(c, 1'b0);
    end
    queue_cmd(draw_cmd(KIND_CLEAR, 0, 0, 0, 0, 1'b0), 1'b0);
    queue_cmd(read_cmd(2 * DISP_WIDTH + 20), 1'b0);

    lx = 0;
    ly = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 999);
      if (r < 10) begin
        c = draw_cmd(KIND_CLEAR, 0, 0, 0, 0, 1'b0);
      end else if (r < 970 && r >= 620) begin
        if ($urandom_range(0, 1) == 0) begin
          c = read_cmd(((ly < 0 ? 0 : (ly >= DISP_HEIGHT ? DISP_HEIGHT - 1 : ly)) / 8)
                       * DISP_WIDTH + (lx < 0 ? 0 : (lx >= DISP_WIDTH ? DISP_WIDTH - 1 : lx)));
        end else begin
          c = read_cmd($urandom_range(0, STORE_BYTES - 1));
        end
      end else if (r >= 970) begin
        c = random_cmd();
        c.kind = 3'($urandom_range(KIND_READ + 1, KIND_LAST));
      end else begin
        lx = pick_x();
        ly = pick_y();
        c = draw_cmd(r < 260 ? KIND_PIXEL : (r < 440 ? KIND_HLINE : KIND_RECT), lx, ly,
                     pick_span(), pick_span(), ($urandom_range(0, 3) != 0));
      end
      queue_cmd(c, (n == 0) || (n == RANDOM_ITEMS / 2));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (!(cmd_queue.size() == 0 && !in_tvalid && result_queue.size() == 0)
           && idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (mismatches == 0 && result_queue.size() == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("SCOREBOARD MISMATCH");
      end
    end
    $finish;
  end

endmodule
